@@ hdl/itr_pkg.sv @@
// Shared constants, the control word type and the digit-to-character function
// for the integer to radix digits block. No dependencies.
package itr_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 31;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 8;
  localparam int STEP_BITS       = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] ERROR_CHAR    = 8'h00;

  typedef struct packed {
    logic               err;
    logic [RADIX_W-1:0] radix;
  } itr_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_BASE) begin
      c = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end else begin
      c = ASCII_UPPER_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DEC_BASE};
    end
    return c;
  endfunction

endpackage

@@ hdl/itr_front.sv @@
// Front end: holds the radix register, accepts input words and classifies them.
// Depends on itr_pkg.
module itr_front #(
  parameter int VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itr_pkg::RADIX_W-1:0]   cfg_radix,
  output logic                          push_valid,
  input  logic                          push_ready,
  output itr_pkg::itr_ctl_t             push_ctl,
  output logic [VALUE_WIDTH-2:0]        push_mag
);
  import itr_pkg::*;

  logic [RADIX_W-1:0]     radix_r;
  logic                   fv_r;
  itr_ctl_t               ctl_r;
  logic [VALUE_WIDTH-2:0] mag_r;
  logic                   take;

  assign in_stall   = fv_r && !push_ready;
  assign take       = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign push_valid = fv_r;
  assign push_ctl   = ctl_r;
  assign push_mag   = mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      fv_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix_r <= cfg_radix;
      end
      if (take) begin
        fv_r <= 1'b1;
      end else if (push_ready) begin
        fv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r.err   <= in_value[VALUE_WIDTH-1] || (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
      ctl_r.radix <= radix_r;
      mag_r       <= in_value[VALUE_WIDTH-2:0];
    end
  end

endmodule

@@ hdl/itr_queue.sv @@
// Short queue of classified words between the front end and the converter.
// Depends on itr_pkg.
module itr_queue #(
  parameter int MAG_W = itr_pkg::VALUE_WIDTH_DEF - 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  itr_pkg::itr_ctl_t push_ctl,
  input  logic [MAG_W-1:0]  push_mag,
  output logic              pop_valid,
  input  logic              pop_ready,
  output itr_pkg::itr_ctl_t pop_ctl,
  output logic [MAG_W-1:0]  pop_mag
);
  import itr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  itr_ctl_t         ctl_q [QUEUE_DEPTH];
  logic [MAG_W-1:0] mag_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_ctl    = ctl_q[rd_ptr_r];
  assign pop_mag    = mag_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_q[wr_ptr_r] <= push_ctl;
      mag_q[wr_ptr_r] <= push_mag;
    end
  end

endmodule

@@ hdl/itr_back.sv @@
// Converter: repeated division by the radix, a few bits per cycle, into a digit
// buffer, then emission most significant digit first. Depends on itr_pkg.
module itr_back #(
  parameter int VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itr_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  itr_pkg::itr_ctl_t          pop_ctl,
  input  logic [VALUE_WIDTH-2:0]     pop_mag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [itr_pkg::CHAR_W-1:0] out_digit_char,
  output logic                       out_last_digit,
  output logic                       out_error_flag
);
  import itr_pkg::*;

  localparam int MAG_W  = VALUE_WIDTH - 1;
  localparam int PASSES = (MAG_W + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W  = PASSES * STEP_BITS;
  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_ERR   = 3'd4;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [PAD_W-1:0]   quot_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [RADIX_W-1:0] radix_r;
  logic [PASS_W-1:0]  pass_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [DIGIT_W-1:0] rd_data_r;
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

  logic [DIGIT_W:0]     acc;
  logic [STEP_BITS-1:0] chunk;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W-1:0]   rem_step;
  logic [PAD_W-1:0]     quot_step;
  logic                 digit_done;
  logic                 div_last;
  logic                 mem_we;

  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;
  logic                 out_err_r;
  logic                 out_free;
  logic                 out_load;
  logic [CHAR_W-1:0]    load_char;
  logic                 load_last;
  logic                 load_err;

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;
  assign out_error_flag = out_err_r;
  assign out_free       = !out_valid_r || !out_stall;
  assign pop_ready      = (state_r == S_IDLE);

  always_comb begin
    acc   = {1'b0, rem_r};
    chunk = quot_r[PAD_W-1 -: STEP_BITS];
    qbits = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      acc = {acc[DIGIT_W-1:0], chunk[STEP_BITS-1-j]};
      qbits[STEP_BITS-1-j] = (acc >= radix_r);
      if (acc >= radix_r) begin
        acc = acc - radix_r;
      end
    end
    rem_step  = acc[DIGIT_W-1:0];
    quot_step = PAD_W'({quot_r, qbits});
  end

  assign digit_done = (state_r == S_DIV) && (pass_r == PASS_W'(PASSES - 1));
  assign div_last   = (quot_step == '0) || (cnt_r == CNT_W'(MAX_DIGITS - 1));
  assign mem_we     = digit_done;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    load_char = ERROR_CHAR;
    load_last = 1'b1;
    load_err  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          state_nxt = pop_ctl.err ? S_ERR : S_DIV;
        end
      end
      S_DIV: begin
        if (digit_done && div_last) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_char = digit_to_ascii(rd_data_r);
          load_last = (rd_idx_r == '0);
          state_nxt = (rd_idx_r == '0) ? S_IDLE : S_FETCH;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_err  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) begin
        out_valid_r <= out_load;
      end
      if (state_r == S_IDLE && pop_valid) begin
        cnt_r <= '0;
      end else if (digit_done) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop_valid) begin
      radix_r <= pop_ctl.radix;
      quot_r  <= PAD_W'(pop_mag);
      rem_r   <= '0;
      pass_r  <= '0;
    end else if (state_r == S_DIV) begin
      quot_r <= quot_step;
      if (digit_done) begin
        rem_r  <= '0;
        pass_r <= '0;
        if (div_last) begin
          rd_idx_r <= cnt_r[IDX_W-1:0];
        end
      end else begin
        rem_r  <= rem_step;
        pass_r <= pass_r + 1'b1;
      end
    end else if (state_r == S_OUT && out_free && rd_idx_r != '0) begin
      rd_idx_r <= rd_idx_r - 1'b1;
    end
    if (out_load) begin
      out_char_r <= load_char;
      out_last_r <= load_last;
      out_err_r  <= load_err;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[IDX_W-1:0]] <= rem_step;
    end
    rd_data_r <= digit_mem[rd_idx_r];
  end

endmodule

@@ hdl/integer_to_radix_digits.sv @@
// Integer to radix digits, top level. Depends on itr_pkg, itr_front, itr_queue, itr_back.
// Each digit comes from one division of the magnitude by the radix, made in passes by the
// eight-bit-per-cycle divide step; the digits are then read back from the buffer one by one.
// An error word skips the division and gives a single flagged word. A two-entry queue lets
// input words wait meanwhile.
// Synchronous active-low reset clears control state and sets the radix to ten.
module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = itr_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itr_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itr_pkg::RADIX_W-1:0]   cfg_radix,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itr_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last_digit,
  output logic                          out_error_flag
);
  import itr_pkg::*;

  logic                   push_valid;
  logic                   push_ready;
  itr_ctl_t               push_ctl;
  logic [VALUE_WIDTH-2:0] push_mag;
  logic                   pop_valid;
  logic                   pop_ready;
  itr_ctl_t               pop_ctl;
  logic [VALUE_WIDTH-2:0] pop_mag;

  itr_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_radix (cfg_radix),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_ctl  (push_ctl),
    .push_mag  (push_mag)
  );

  itr_queue #(
    .MAG_W(VALUE_WIDTH - 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_ctl  (push_ctl),
    .push_mag  (push_mag),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_ctl   (pop_ctl),
    .pop_mag   (pop_mag)
  );

  itr_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_ctl       (pop_ctl),
    .pop_mag       (pop_mag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit),
    .out_error_flag(out_error_flag)
  );

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_last_digit && (out_digit_char == ERROR_CHAR))
    else $error("error word is not a single last word");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error_flag |->
      (out_digit_char >= ASCII_ZERO && out_digit_char <= ASCII_NINE) ||
      (out_digit_char >= ASCII_UPPER_A && out_digit_char <= ASCII_UPPER_F))
    else $error("digit word outside the digit character set");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_digit |=> !out_valid || !out_error_flag)
    else $error("error word inside a run of digits");
`endif

endmodule
